@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hw/rtl/lrb_pkg.sv @@
// Package for the Legendre root bisection block: payload types, constants, reciprocals.
// No dependencies.
`default_nettype none
package lrb_pkg;
    localparam int MAX_DEGREE = 64;
    localparam int FRAC_BITS  = 30;
    localparam int DEG_W      = 7;
    localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
    localparam logic signed [33:0] ONE_FX = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] MONE_FX = -(34'sd1 <<< FRAC_BITS);

    typedef struct packed {
        logic signed [31:0] prev_root;
        logic               prev_last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] root;
        logic               root_last;
    } out_item_t;

    typedef logic [MAX_DEGREE:0][31:0] recip_tab_t;

    function automatic recip_tab_t make_recip_tab();
        recip_tab_t tab;
        tab[0] = '0;
        for (int i = 1; i <= MAX_DEGREE; i++)
            tab[i] = 32'((64'd1 << FRAC_BITS) / 64'(i));
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = make_recip_tab();
endpackage
`default_nettype wire

@@ hw/rtl/lrb_datapath.sv @@
// Datapath: bracket registers and a sequential Legendre recurrence evaluator.
// Depends on lrb_pkg.
`default_nettype none
module lrb_datapath import lrb_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [DEG_W-1:0]   n,
    input  wire logic signed [33:0] a_in,
    input  wire logic signed [33:0] c_in,
    input  wire logic               go,
    output logic                    busy,
    output logic signed [33:0]      result
);
    typedef enum logic [2:0] {S_IDLE, S_MID, S_EA, S_MUL1, S_MUL2, S_DEC} st_t;
    st_t st_reg, st_next;
    logic signed [33:0] a_reg, a_next, c_reg, c_next, b_reg, b_next, x_reg, x_next;
    logic signed [33:0] pm1_reg, pm1_next, pm2_reg, pm2_next, fa_reg, fa_next;
    logic signed [33:0] t_reg, t_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic               side_reg, side_next;
    logic signed [34:0] sum;
    logic signed [33:0] mid, mop_a, mop_b, mq, pnew;
    logic signed [35:0] pr;
    logic [67:0]        mag;
    logic [33:0]        ua, ub;

    assign sum = 35'(a_reg) + 35'(c_reg);
    assign mid = sum[34:1];

    always_comb
    begin
        mop_a = x_reg;
        mop_b = pm1_reg;
        if (st_reg == S_MUL2)
        begin
            mop_a = $signed({2'b00, RECIP_TAB[i_reg]});
            mop_b = t_reg - pm2_reg;
        end
        ua = mop_a[33] ? 34'(-mop_a) : 34'(mop_a);
        ub = mop_b[33] ? 34'(-mop_b) : 34'(mop_b);
        mag = 68'(ua) * 68'(ub);
        mq = (mop_a[33] ^ mop_b[33]) ? -$signed(mag[63:30]) : $signed(mag[63:30]);
        pr = 36'(t_reg) * 36'sd2 - 36'(pm2_reg) - 36'(mq);
        if (pr > 36'(ONE_FX)) pnew = ONE_FX;
        else if (pr < 36'(MONE_FX)) pnew = MONE_FX;
        else pnew = pr[33:0];
    end

    always_comb
    begin
        st_next = st_reg; a_next = a_reg; c_next = c_reg; b_next = b_reg; x_next = x_reg;
        pm1_next = pm1_reg; pm2_next = pm2_reg; fa_next = fa_reg; t_next = t_reg;
        i_next = i_reg; side_next = side_reg;
        case (st_reg)
            S_IDLE:
                if (go)
                begin
                    a_next = a_in; c_next = c_in; st_next = S_MID;
                end
            S_MID:
            begin
                b_next = mid;
                if (mid == a_reg || mid == c_reg) st_next = S_IDLE;
                else
                begin
                    x_next = a_reg; pm1_next = a_reg; pm2_next = ONE_FX;
                    i_next = CNT_W'(2); side_next = 1'b0; st_next = S_MUL1;
                end
            end
            S_MUL1:
                if (i_reg > CNT_W'(n)) st_next = side_reg ? S_DEC : S_EA;
                else
                begin
                    t_next = mq; st_next = S_MUL2;
                end
            S_MUL2:
            begin
                pm2_next = pm1_reg; pm1_next = pnew; i_next = i_reg + 1'b1; st_next = S_MUL1;
            end
            S_EA:
            begin
                fa_next = pm1_reg; x_next = b_reg; pm1_next = b_reg; pm2_next = ONE_FX;
                i_next = CNT_W'(2); side_next = 1'b1; st_next = S_MUL1;
            end
            S_DEC:
            begin
                if (pm1_reg == 0) st_next = S_IDLE;
                else
                begin
                    if ((fa_reg < 0 && pm1_reg > 0) || (fa_reg > 0 && pm1_reg < 0))
                        c_next = b_reg;
                    else a_next = b_reg;
                    st_next = S_MID;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= S_IDLE;
        else st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; c_reg <= c_next; b_reg <= b_next; x_reg <= x_next;
        pm1_reg <= pm1_next; pm2_reg <= pm2_next; fa_reg <= fa_next; t_reg <= t_next;
        i_reg <= i_next; side_reg <= side_next;
    end

    assign busy = (st_reg != S_IDLE) || go;
    assign result = b_reg;
endmodule
`default_nettype wire

@@ hw/rtl/lrb_ctrl.sv @@
// Controller: handshake, left end, sequencing of up to two bisections per transaction.
// Depends on lrb_pkg.
`default_nettype none
module lrb_ctrl import lrb_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [DEG_W-1:0]   cfg_data,
    input  wire in_item_t           in_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output out_item_t               out_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DEG_W-1:0]        n,
    output logic signed [33:0]      a_out,
    output logic signed [33:0]      c_out,
    output logic                    go,
    input  wire logic               dp_busy,
    input  wire logic signed [33:0] dp_result
);
    typedef enum logic [2:0] {C_IDLE, C_RUN1, C_OUT1, C_RUN2, C_OUT2} cst_t;
    cst_t st_reg;
    logic [DEG_W-1:0]   deg_reg;
    logic signed [33:0] left_reg, left_next, x_reg;
    logic               last_reg, ov_reg;
    out_item_t          od_reg, od_next;
    logic signed [33:0] xin;
    logic               acc, deg_le1, out_free, out_load;

    assign deg_le1 = deg_reg <= DEG_W'(1);
    assign n = (deg_reg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_reg;
    assign out_free = !(ov_reg && out_stall);
    assign in_stall = (st_reg != C_IDLE) || !out_free;
    assign acc = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data = od_reg;

    always_comb
    begin
        xin = 34'(in_data.prev_root);
        if (xin > ONE_FX) xin = ONE_FX;
        else if (xin < MONE_FX) xin = MONE_FX;
        go = 1'b0; a_out = left_reg; c_out = xin;
        if (acc && !deg_le1) go = 1'b1;
        else if (st_reg == C_OUT1 && last_reg && out_free)
        begin
            go = 1'b1; a_out = x_reg; c_out = ONE_FX;
        end
    end

    always_comb
    begin
        out_load = 1'b0; od_next = od_reg; left_next = left_reg;
        case (st_reg)
            C_IDLE:
                if (acc && deg_le1)
                begin
                    out_load = 1'b1; od_next = '{root: 32'sd0, root_last: 1'b1};
                    left_next = MONE_FX;
                end
            C_OUT1:
                if (out_free)
                begin
                    out_load = 1'b1; od_next = '{root: dp_result[31:0], root_last: 1'b0};
                    if (!last_reg) left_next = x_reg;
                end
            C_OUT2:
                if (out_free)
                begin
                    out_load = 1'b1; od_next = '{root: dp_result[31:0], root_last: 1'b1};
                    left_next = MONE_FX;
                end
            default: ;
        endcase
        if (cfg_we) left_next = MONE_FX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_IDLE; deg_reg <= DEG_W'(1); left_reg <= MONE_FX; ov_reg <= 1'b0;
            x_reg <= '0; last_reg <= 1'b0; od_reg <= '0;
        end
        else
        begin
            ov_reg <= out_load || (ov_reg && out_stall);
            od_reg <= od_next;
            left_reg <= left_next;
            if (cfg_we) deg_reg <= cfg_data;
            case (st_reg)
                C_IDLE:
                    if (acc)
                    begin
                        x_reg <= xin; last_reg <= in_data.prev_last;
                        if (!deg_le1) st_reg <= C_RUN1;
                    end
                C_RUN1:
                    if (!dp_busy) st_reg <= C_OUT1;
                C_OUT1:
                    if (out_free) st_reg <= last_reg ? C_RUN2 : C_IDLE;
                C_RUN2:
                    if (!dp_busy) st_reg <= C_OUT2;
                C_OUT2:
                    if (out_free) st_reg <= C_IDLE;
                default: st_reg <= C_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/legendre_root_bisection.sv @@
// Top level of the Legendre root bisection block.
// Depends on lrb_pkg, lrb_ctrl, lrb_datapath.
// Each transaction in yields one root (two on the last of a set when the degree is
// above one). Each bisection step runs the recurrence for both points through one
// shared multiplier, up to 31 steps per root.
`default_nettype none
module legendre_root_bisection import lrb_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [DEG_W-1:0] cfg_data,
    input  wire in_item_t         in_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output out_item_t             out_data,
    output logic                  out_valid,
    input  wire logic             out_stall
);
    logic [DEG_W-1:0]   n;
    logic signed [33:0] a, c, res;
    logic               go, busy;

    lrb_ctrl u_ctrl (
        .clk, .rst_n, .cfg_we, .cfg_data, .in_data, .in_valid, .in_stall,
        .out_data, .out_valid, .out_stall, .n, .a_out(a), .c_out(c), .go,
        .dp_busy(busy), .dp_result(res)
    );

    lrb_datapath u_dp (
        .clk, .rst_n, .n, .a_in(a), .c_in(c), .go, .busy, .result(res)
    );
endmodule
`default_nettype wire

@@ hw/rtl/lrb_checker.sv @@
// Port checker for legendre_root_bisection, bound to the top level.
// Depends on lrb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lrb_checker import lrb_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire out_item_t out_data,
    input wire logic      out_valid,
    input wire logic      out_stall
);
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "output changed while stalled")
    `ASSERT_CLK(a_busy_after, clk, rst_n, in_valid && !in_stall |=> in_stall || out_valid, "accepted transaction left no trace")
    `ASSERT_CLK(a_root_range, clk, rst_n, out_valid |-> (out_data.root <= 32'sd1073741824) && (out_data.root >= -32'sd1073741824), "root out of range")
    `ASSERT_NORST(a_rst_idle, clk, !rst_n |-> !out_valid, "output valid in reset")
endmodule
bind legendre_root_bisection lrb_checker u_lrb_checker (.*);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for legendre_root_bisection: directed table, then random root sets.
// Depends on lrb_pkg for the payload types; expected roots come from a local bisection predictor.
module tb_top;
    import lrb_pkg::*;

    localparam longint ONE_Q = 64'sd1 <<< 30;
    localparam int MAX_N = 64;
    localparam int DRAIN_CYCLES = 50;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_data;
    in_item_t in_data;
    logic in_valid;
    logic in_stall;
    out_item_t out_data;
    logic out_valid;
    logic out_stall;

    out_item_t pending_roots[$];
    longint bracket_left;
    int unsigned poly_degree;
    int fail_cnt;
    int accepted_cnt;
    longint cycle_cnt;
    longint recip_q[MAX_N + 1];
    bit stall_quiet;
    int stall_left;

    typedef struct {
        bit wr;
        logic [6:0] deg;
        in_item_t item;
        bit typed;
        out_item_t res;
    } stim_row_t;

    legendre_root_bisection i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_data(in_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_data(out_data),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint sat_one(longint v);
        if (v > ONE_Q) return ONE_Q;
        if (v < -ONE_Q) return -ONE_Q;
        return v;
    endfunction

    function automatic longint mul_q(longint a, longint b);
        logic [127:0] prod;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] mag;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = ua * ub;
        mag = prod[93:30];
        mag[63] = 1'b0;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint legendre_at(int unsigned n, longint x);
        longint p1;
        longint p2;
        longint p;
        longint t;
        if (n == 0) return ONE_Q;
        if (n == 1) return x;
        p1 = x;
        p2 = ONE_Q;
        p = x;
        for (int i = 2; i <= n && i <= MAX_N; i++) begin
            t = mul_q(x, p1);
            p = sat_one(2 * t - p2 - mul_q(recip_q[i], t - p2));
            p2 = p1;
            p1 = p;
        end
        return p;
    endfunction

    function automatic longint half_floor(longint v);
        return v >= 0 ? v / 2 : -((-v + 1) / 2);
    endfunction

    function automatic longint bisect_root(int unsigned n, longint a, longint c);
        longint b;
        longint fa;
        longint fb;
        forever begin
            b = half_floor(a + c);
            if (b == a || b == c) break;
            fa = legendre_at(n, a);
            fb = legendre_at(n, b);
            if (fb == 0) break;
            if ((fa < 0 && fb > 0) || (fa > 0 && fb < 0)) c = b;
            else a = b;
        end
        return b;
    endfunction

    function automatic void predict_roots(in_item_t it, bit typed, out_item_t typed_res);
        longint x;
        int unsigned n;
        out_item_t r;
        n = poly_degree > MAX_N ? MAX_N : poly_degree;
        x = sat_one(longint'(it.prev_root));
        if (n <= 1) begin
            r.root = '0;
            r.root_last = 1'b1;
            bracket_left = -ONE_Q;
            pending_roots = {pending_roots, (typed ? typed_res : r)};
            return;
        end
        r.root = 32'(bisect_root(n, bracket_left, x));
        r.root_last = 1'b0;
        pending_roots = {pending_roots, r};
        if (!it.prev_last) begin
            bracket_left = x;
            return;
        end
        r.root = 32'(bisect_root(n, x, ONE_Q));
        r.root_last = 1'b1;
        pending_roots = {pending_roots, r};
        bracket_left = -ONE_Q;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        accepted_cnt++;
        predict_roots(it, typed, typed_res);
    endtask

    task automatic set_degree(logic [6:0] d);
        in_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_data <= d;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        poly_degree = d;
        bracket_left = -ONE_Q;
    endtask

    // hold out_stall in bursts, with quiet stretches
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_quiet <= ~stall_quiet;
            if (!stall_quiet && $urandom_range(0, 9) == 0) begin
                stall_left <= pick_gap();
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_roots.size() == 0) begin
                $error("unexpected transaction: root=%0d root_last=%0b",
                       out_data.root, out_data.root_last);
                fail_cnt++;
            end else begin
                exp_r = pending_roots.pop_front();
                if (out_data.root !== exp_r.root) begin
                    $error("root: expected %0d, actual %0d", exp_r.root, out_data.root);
                    fail_cnt++;
                end
                if (out_data.root_last !== exp_r.root_last) begin
                    $error("root_last: expected %0b, actual %0b",
                           exp_r.root_last, out_data.root_last);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** legendre_root_bisection: FAILED **");
            $finish;
        end
    end

    function automatic stim_row_t row(bit wr, logic [6:0] deg, logic [31:0] v, bit last,
                                      bit typed);
        stim_row_t s;
        s.wr = wr;
        s.deg = deg;
        s.item.prev_root = v;
        s.item.prev_last = last;
        s.typed = typed;
        s.res.root = '0;
        s.res.root_last = 1'b1;
        return s;
    endfunction

    initial begin
        stim_row_t dir_rows[$];
        out_item_t none_res;
        in_item_t it;
        int vals[$];
        int n;
        int cnt;
        bit noisy;

        cycle_cnt = 0;
        fail_cnt = 0;
        accepted_cnt = 0;
        stall_quiet = 1'b0;
        stall_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        none_res = '0;
        recip_q[0] = 0;
        for (int i = 1; i <= MAX_N; i++) recip_q[i] = ONE_Q / i;
        poly_degree = 1;
        bracket_left = -ONE_Q;

        dir_rows = {dir_rows, row(0, 7'd1, 32'h4000_0000, 0, 1)};
        dir_rows = {dir_rows, row(0, 7'd1, 32'hC000_0000, 1, 1)};
        dir_rows = {dir_rows, row(1, 7'd0, 32'h7FFF_FFFF, 0, 1)};
        dir_rows = {dir_rows, row(0, 7'd0, 32'h8000_0000, 1, 1)};
        dir_rows = {dir_rows, row(1, 7'd2, 32'h0000_0000, 1, 0)};
        dir_rows = {dir_rows, row(1, 7'd3, -32'sd619925131, 0, 0)};
        dir_rows = {dir_rows, row(0, 7'd3, 32'sd619925131, 1, 0)};
        dir_rows = {dir_rows, row(1, 7'd2, 32'h8000_0000, 0, 0)};
        dir_rows = {dir_rows, row(0, 7'd2, 32'h7FFF_FFFF, 1, 0)};
        dir_rows = {dir_rows, row(0, 7'd2, 32'h2000_0000, 0, 0)};
        dir_rows = {dir_rows, row(0, 7'd2, 32'hE000_0000, 1, 0)};
        dir_rows = {dir_rows, row(1, 7'd5, 32'hF000_0000, 0, 0)};
        dir_rows = {dir_rows, row(0, 7'd5, 32'h1000_0000, 1, 0)};
        dir_rows = {dir_rows, row(0, 7'd5, 32'h4000_0000, 1, 0)};
        dir_rows = {dir_rows, row(1, 7'd64, 32'h0000_0000, 1, 0)};
        dir_rows = {dir_rows, row(1, 7'd127, 32'h1000_0000, 1, 0)};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].wr) set_degree(dir_rows[i].deg);
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        end

        while (accepted_cnt < 140) begin
            cnt = $urandom_range(0, 99);
            if (cnt < 88) n = $urandom_range(2, 8);
            else if (cnt < 94) n = $urandom_range(0, 1);
            else n = $urandom_range(9, 20);
            set_degree(7'(n));
            cnt = ($urandom_range(0, 9) < 8 && n > 1) ? n - 1 : $urandom_range(1, 4);
            vals.delete();
            for (int k = 0; k < cnt; k++)
                vals = {vals, int'(longint'($urandom_range(0, 32'h8000_0000)) - ONE_Q)};
            vals.sort();
            for (int k = 0; k < cnt; k++) begin
                noisy = $urandom_range(0, 9) == 0;
                it.prev_root = noisy ? 32'($urandom) : 32'(vals[k]);
                it.prev_last = (k == cnt - 1) ? ($urandom_range(0, 19) != 0) : noisy;
                send_item(it, 0, none_res);
            end
        end

        in_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("** legendre_root_bisection: PASSED **");
        else
            $display("** legendre_root_bisection: FAILED **");
        $finish;
    end
endmodule

@@ legendre_root_bisection.f @@
+incdir+hw/rtl
hw/rtl/lrb_pkg.sv
hw/rtl/lrb_datapath.sv
hw/rtl/lrb_ctrl.sv
hw/rtl/legendre_root_bisection.sv
hw/rtl/lrb_checker.sv
tb/sv/tb_top.sv
